/* rtl/itma_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package itma_pkg;

    localparam int SAMPLES_PER_CHANNEL = 10;
    localparam int CHANNELS            = 4;
    localparam int CH_W                = $clog2(CHANNELS);
    localparam int SAMPLE_W            = 12;
    localparam int SAMPLE_MAX          = (1 << SAMPLE_W) - 1;
    localparam int TRIM_COUNT          = 2;
    localparam int TRIM_DIV            = SAMPLES_PER_CHANNEL - TRIM_COUNT;

    localparam int SUM_W   = $clog2(SAMPLES_PER_CHANNEL * SAMPLE_MAX + 1);
    localparam int FRAME_W = $clog2(SAMPLES_PER_CHANNEL);
    localparam int DIV_W   = $clog2(TRIM_DIV + 1);

    // reciprocal multiply, estimate is exact or one low
    localparam int DIV_SHIFT = SUM_W + 6;
    localparam int MULT_W    = DIV_SHIFT + 1;
    localparam int PROD_W    = SUM_W + MULT_W;
    localparam logic [MULT_W-1:0] DIV_MULT = MULT_W'((64'd1 << DIV_SHIFT) / TRIM_DIV);

    localparam int LEVEL_W   = 16;
    localparam int LEVEL_MAX = (1 << LEVEL_W) - 1;
    localparam int BASE_W    = 16;
    localparam int OFFSET_W  = 13;
    localparam int CALC_W    = ((SUM_W > BASE_W) ? SUM_W : BASE_W) + 2;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_BASE       = 3'd0,
        REG_OFFSET_CH0 = 3'd1,
        REG_OFFSET_CH1 = 3'd2,
        REG_OFFSET_CH2 = 3'd3,
        REG_OFFSET_CH3 = 3'd4
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_READ,
        ST_DIVIDE,
        ST_CORRECT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [SUM_W-1:0]    sum;
        logic [SAMPLE_W-1:0] peak;
        logic [SAMPLE_W-1:0] floor_val;
    } entry_t;

endpackage

`default_nettype wire

/* rtl/interleaved_trimmed_mean_averager_top.sv */
// Channel   Direction  Handshake             Payload
// in        in         in_valid / in_ready   sample
// out       out        out_valid / out_ready channel, level, last
// cfg       in         cfg_we                cfg_index, cfg_data
//
// A sample is handled as a memory read, then a modify and write back.
// After the last sample of a frame each channel steps through read, reciprocal
// multiply, correction and emit, one channel after another.
// Output stalls hold the emit step; no request is taken until all four are loaded.
// Reset clears control and config; the frame memory is rebuilt by the first round.
`timescale 1ns / 1ps
`default_nettype none

module interleaved_trimmed_mean_averager_top (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [itma_pkg::SAMPLE_W-1:0]    sample,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [itma_pkg::CH_W-1:0]             channel,
    output logic [itma_pkg::LEVEL_W-1:0]          level,
    output logic                                  last,
    input  wire logic                             cfg_we,
    input  wire logic [itma_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [itma_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import itma_pkg::*;

    state_t                      state_reg, state_next;
    logic [FRAME_W-1:0]          frame_pos_reg, frame_pos_next;
    logic [CH_W-1:0]             lane_reg, lane_next;
    logic [CH_W-1:0]             k_reg, k_next;
    logic [SAMPLE_W-1:0]         sample_reg, sample_next;
    logic [SUM_W-1:0]            rest_reg, rest_next;
    logic [SUM_W-1:0]            q0_reg, q0_next;
    logic [SUM_W-1:0]            q_reg, q_next;
    logic                        out_valid_reg, out_valid_next;
    logic [CH_W-1:0]             channel_reg, channel_next;
    logic [LEVEL_W-1:0]          level_reg, level_next;
    logic                        last_reg, last_next;

    logic signed [BASE_W-1:0]    base_reg;
    logic signed [OFFSET_W-1:0]  offset_reg [CHANNELS];

    entry_t                      mem [CHANNELS];
    entry_t                      rdata;
    entry_t                      wdata;
    logic [CH_W-1:0]             raddr;
    logic                        mem_we;

    logic                        frame_end;
    logic                        emit_fire;
    logic [PROD_W-1:0]           prod;
    logic [SUM_W-1:0]            rem;
    logic signed [CALC_W-1:0]    calc;

    assign frame_end = (lane_reg == CH_W'(CHANNELS - 1))
        && (({1'b0, frame_pos_reg} + (FRAME_W+1)'(1)) == (FRAME_W+1)'(SAMPLES_PER_CHANNEL));
    assign emit_fire = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign channel   = channel_reg;
    assign level     = level_reg;
    assign last      = last_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[lane_reg] <= wdata;
        end
        rdata <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                offset_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BASE:       base_reg      <= cfg_data[BASE_W-1:0];
                REG_OFFSET_CH0: offset_reg[0] <= cfg_data[OFFSET_W-1:0];
                REG_OFFSET_CH1: offset_reg[1] <= cfg_data[OFFSET_W-1:0];
                REG_OFFSET_CH2: offset_reg[2] <= cfg_data[OFFSET_W-1:0];
                REG_OFFSET_CH3: offset_reg[3] <= cfg_data[OFFSET_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:  state_next = frame_end ? ST_READ : ST_IDLE;
            ST_READ:    state_next = ST_DIVIDE;
            ST_DIVIDE:  state_next = ST_CORRECT;
            ST_CORRECT: state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (emit_fire)
                begin
                    state_next = (k_reg == CH_W'(CHANNELS - 1)) ? ST_IDLE : ST_READ;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        frame_pos_next = frame_pos_reg;
        lane_next      = lane_reg;
        k_next         = k_reg;
        sample_next    = sample_reg;
        rest_next      = rest_reg;
        q0_next        = q0_reg;
        q_next         = q_reg;
        out_valid_next = out_valid_reg;
        channel_next   = channel_reg;
        level_next     = level_reg;
        last_next      = last_reg;
        raddr          = lane_reg;
        mem_we         = 1'b0;
        wdata          = rdata;
        prod           = '0;
        rem            = '0;
        calc           = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                sample_next = sample;
            end
            ST_UPDATE:
            begin
                mem_we = 1'b1;
                if (frame_pos_reg == '0)
                begin
                    wdata.sum       = SUM_W'(sample_reg);
                    wdata.peak      = sample_reg;
                    wdata.floor_val = sample_reg;
                end
                else
                begin
                    wdata.sum = rdata.sum + SUM_W'(sample_reg);
                    if (sample_reg > rdata.peak)
                    begin
                        wdata.peak = sample_reg;
                    end
                    if (sample_reg < rdata.floor_val)
                    begin
                        wdata.floor_val = sample_reg;
                    end
                end
                lane_next = lane_reg + CH_W'(1);
                k_next    = '0;
                if (lane_reg == CH_W'(CHANNELS - 1) && !frame_end)
                begin
                    frame_pos_next = frame_pos_reg + FRAME_W'(1);
                end
            end
            ST_READ:
            begin
                raddr = k_reg;
            end
            ST_DIVIDE:
            begin
                rest_next = rdata.sum - SUM_W'(rdata.peak) - SUM_W'(rdata.floor_val);
                prod      = PROD_W'(rest_next) * PROD_W'(DIV_MULT);
                q0_next   = prod[DIV_SHIFT +: SUM_W];
            end
            ST_CORRECT:
            begin
                rem    = rest_reg - SUM_W'(q0_reg * SUM_W'(TRIM_DIV));
                q_next = (rem >= SUM_W'(TRIM_DIV)) ? q0_reg + SUM_W'(1) : q0_reg;
            end
            ST_EMIT:
            begin
                calc = CALC_W'(q_reg) + CALC_W'(base_reg) - CALC_W'(offset_reg[k_reg]);
                if (emit_fire)
                begin
                    out_valid_next = 1'b1;
                    channel_next   = k_reg;
                    last_next      = (k_reg == CH_W'(CHANNELS - 1));
                    if (calc < 0)
                    begin
                        level_next = '0;
                    end
                    else if (calc > CALC_W'(LEVEL_MAX))
                    begin
                        level_next = LEVEL_W'(LEVEL_MAX);
                    end
                    else
                    begin
                        level_next = calc[LEVEL_W-1:0];
                    end
                    k_next = k_reg + CH_W'(1);
                    if (k_reg == CH_W'(CHANNELS - 1))
                    begin
                        frame_pos_next = '0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            frame_pos_reg <= '0;
            lane_reg      <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            frame_pos_reg <= frame_pos_next;
            lane_reg      <= lane_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg  <= sample_next;
        rest_reg    <= rest_next;
        q0_reg      <= q0_next;
        q_reg       <= q_next;
        channel_reg <= channel_next;
        level_reg   <= level_next;
        last_reg    <= last_next;
    end

`ifndef SYNTHESIS
    a_accept_updates: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_UPDATE))
        else $error("accepted sample not followed by update");

    a_emit_lane_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ || state_reg == ST_DIVIDE || state_reg == ST_CORRECT
         || state_reg == ST_EMIT) |-> (lane_reg == '0))
        else $error("lane moved during frame emission");

    a_last_on_final: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last) |-> (channel == CH_W'(CHANNELS - 1)))
        else $error("last flag on wrong channel");

    a_quotient_exact: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |->
        ((PROD_W'(q_reg) * PROD_W'(TRIM_DIV) <= PROD_W'(rest_reg))
         && (PROD_W'(rest_reg) < (PROD_W'(q_reg) + PROD_W'(1)) * PROD_W'(TRIM_DIV))))
        else $error("trimmed mean quotient out of range");
`endif

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import itma_pkg::*;

    typedef struct {
        logic [CH_W-1:0]    channel;
        logic [LEVEL_W-1:0] level;
        logic               last;
    } level_t;

    typedef enum int {
        FILL_ZERO,
        FILL_FULL,
        FILL_UNIFORM,
        FILL_NARROW,
        FILL_EXTREME,
        FILL_TIES
    } fill_t;

    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 300;
    localparam int FRAME_ITEMS   = CHANNELS * SAMPLES_PER_CHANNEL;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic [SAMPLE_W-1:0]    sample;
    logic                   out_valid;
    logic                   out_ready;
    logic [CH_W-1:0]        channel;
    logic [LEVEL_W-1:0]     level;
    logic                   last;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    logic signed [BASE_W-1:0]   base_reg;
    logic signed [OFFSET_W-1:0] offset_reg [CHANNELS];
    logic [17:0]                acc_sum    [CHANNELS];
    logic [SAMPLE_W-1:0]        acc_peak   [CHANNELS];
    logic [SAMPLE_W-1:0]        acc_floor  [CHANNELS];
    logic [CH_W-1:0]            next_lane;
    int                         rounds_done;

    level_t level_q [$];
    int     mismatches = 0;
    bit     idle_en    = 1'b1;
    int     hold_cnt   = 0;
    int     stall_cnt  = 0;

    interleaved_trimmed_mean_averager_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .sample    (sample),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .channel   (channel),
        .level     (level),
        .last      (last),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic clear_frame_model();
        int c;
        for (c = 0; c < CHANNELS; c++)
        begin
            acc_sum[c]   = '0;
            acc_peak[c]  = '0;
            acc_floor[c] = SAMPLE_W'(SAMPLE_MAX);
        end
        next_lane   = '0;
        rounds_done = 0;
    endtask

    // trimmed mean per channel once the last round of a frame is in
    task automatic absorb_sample(input logic [SAMPLE_W-1:0] s);
        int     k;
        int     rest;
        int     v;
        level_t r;
        acc_sum[next_lane] = acc_sum[next_lane] + 18'(s);
        if (s > acc_peak[next_lane])
            acc_peak[next_lane] = s;
        if (s < acc_floor[next_lane])
            acc_floor[next_lane] = s;
        next_lane = next_lane + CH_W'(1);
        if (next_lane == '0)
        begin
            rounds_done++;
            if (rounds_done == SAMPLES_PER_CHANNEL)
            begin
                for (k = 0; k < CHANNELS; k++)
                begin
                    rest = int'(acc_sum[k]) - int'(acc_peak[k]) - int'(acc_floor[k]);
                    v = rest / TRIM_DIV + int'(base_reg) - int'(offset_reg[k]);
                    if (v < 0)
                        v = 0;
                    if (v > LEVEL_MAX)
                        v = LEVEL_MAX;
                    r.channel = CH_W'(k);
                    r.level   = LEVEL_W'(v);
                    r.last    = (k == CHANNELS - 1);
                    level_q.push_back(r);
                end
                clear_frame_model();
            end
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == REG_BASE)
            base_reg = data[BASE_W-1:0];
        else if (idx >= REG_OFFSET_CH0 && idx <= REG_OFFSET_CH3)
            offset_reg[idx - REG_OFFSET_CH0] = data[OFFSET_W-1:0];
    endtask

    task automatic send_sample(input logic [SAMPLE_W-1:0] s);
        int gap;
        if (idle_en && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 4);
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        sample   = s;
        do
            @(posedge clk);
        while (!in_ready);
        absorb_sample(s);
        @(negedge clk);
    endtask

    task automatic send_frame(input fill_t fill);
        int                  center;
        int                  lo;
        int                  hi;
        int                  v;
        logic [SAMPLE_W-1:0] s;
        center = $urandom_range(0, SAMPLE_MAX);
        lo     = $urandom_range(0, SAMPLE_MAX);
        hi     = $urandom_range(lo, SAMPLE_MAX);
        repeat (FRAME_ITEMS)
        begin
            case (fill)
                FILL_ZERO: s = '0;
                FILL_FULL: s = SAMPLE_W'(SAMPLE_MAX);
                FILL_NARROW:
                begin
                    v = center + int'($urandom_range(0, 40)) - 20;
                    if (v < 0)
                        v = 0;
                    if (v > SAMPLE_MAX)
                        v = SAMPLE_MAX;
                    s = SAMPLE_W'(v);
                end
                FILL_EXTREME:
                    case ($urandom_range(0, 2))
                        0:       s = '0;
                        1:       s = SAMPLE_W'(SAMPLE_MAX);
                        default: s = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
                    endcase
                FILL_TIES:
                    case ($urandom_range(0, 3))
                        0:       s = SAMPLE_W'(lo);
                        1:       s = SAMPLE_W'(hi);
                        default: s = SAMPLE_W'($urandom_range(lo, hi));
                    endcase
                default: s = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
            endcase
            send_sample(s);
        end
    endtask

    // drop valid, drain pending results, let the pipeline go quiet
    task automatic settle();
        in_valid = 1'b0;
        while (level_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_all_offsets(input logic [CFG_DATA_W-1:0] data);
        int c;
        for (c = 0; c < CHANNELS; c++)
            write_reg(CFG_INDEX_W'(int'(REG_OFFSET_CH0) + c), data);
    endtask

    task automatic randomize_config();
        int c;
        int b;
        int off;
        case ($urandom_range(0, 3))
            0:       b = -32768;
            1:       b = 32767;
            default: b = int'($urandom_range(0, 8000)) - 2000;
        endcase
        write_reg(REG_BASE, CFG_DATA_W'(b));
        for (c = 0; c < CHANNELS; c++)
        begin
            case ($urandom_range(0, 3))
                0:       off = -4096;
                1:       off = 4095;
                default: off = int'($urandom_range(0, 8191)) - 4096;
            endcase
            // upper bits beyond the offset width are junk
            write_reg(CFG_INDEX_W'(int'(REG_OFFSET_CH0) + c),
                      {3'($urandom_range(0, 7)), 13'(off)});
        end
    endtask

    task automatic test_zero_frame();
        send_frame(FILL_ZERO);
        settle();
    endtask

    task automatic test_full_scale();
        write_reg(REG_BASE, 16'h7FFF);
        write_all_offsets(16'h1000);
        send_frame(FILL_FULL);
        settle();
    endtask

    task automatic test_floor_clamp();
        write_reg(REG_BASE, 16'h8000);
        write_all_offsets(16'h0FFF);
        send_frame(FILL_UNIFORM);
        settle();
    endtask

    task automatic test_unused_index();
        int i;
        for (i = int'(REG_OFFSET_CH3) + 1; i < (1 << CFG_INDEX_W); i++)
            write_reg(CFG_INDEX_W'(i), 16'hFFFF);
        send_frame(FILL_TIES);
        settle();
    endtask

    task automatic test_partial_frame();
        repeat (3) send_sample(SAMPLE_W'($urandom_range(0, SAMPLE_MAX)));
        settle();
        repeat (FRAME_ITEMS - 3) send_sample(SAMPLE_W'($urandom_range(0, SAMPLE_MAX)));
        settle();
    endtask

    task automatic test_backpressure();
        hold_cnt = HOLD_CYCLES;
        send_frame(FILL_UNIFORM);
        send_frame(FILL_EXTREME);
        settle();
    endtask

    task automatic test_random_frames();
        randomize_config();
        send_frame(fill_t'($urandom_range(int'(FILL_UNIFORM), int'(FILL_TIES))));
        settle();
    endtask

    task automatic test_steady_stream();
        idle_en = 1'b0;
        randomize_config();
        send_frame(FILL_NARROW);
        settle();
    endtask

    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_cnt > 0)
            begin
                out_ready = 1'b0;
                hold_cnt--;
            end
            else if (stall_cnt > 0)
            begin
                out_ready = 1'b0;
                stall_cnt--;
            end
            else if (idle_en && $urandom_range(0, 4) == 0)
            begin
                out_ready = 1'b0;
                stall_cnt = $urandom_range(0, 3);
            end
            else
                out_ready = 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_results
        level_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (level_q.size() == 0)
            begin
                $error("unexpected result: channel %0d level %0d last %0d",
                       channel, level, last);
                mismatches++;
            end
            else
            begin
                want = level_q.pop_front();
                if (channel !== want.channel)
                begin
                    $error("channel: expected %0d, actual %0d", want.channel, channel);
                    mismatches++;
                end
                if (level !== want.level)
                begin
                    $error("level: expected %0d, actual %0d", want.level, level);
                    mismatches++;
                end
                if (last !== want.last)
                begin
                    $error("last: expected %0d, actual %0d", want.last, last);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        sample    = '0;
        cfg_we    = 1'b0;
        cfg_index = REG_BASE;
        cfg_data  = '0;
        base_reg  = '0;
        for (int c = 0; c < CHANNELS; c++)
            offset_reg[c] = '0;
        clear_frame_model();
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_zero_frame();
        test_full_scale();
        test_floor_clamp();
        test_unused_index();
        test_partial_frame();
        test_backpressure();
        test_random_frames();
        test_steady_stream();

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* filelist.f */
rtl/itma_pkg.sv
rtl/interleaved_trimmed_mean_averager_top.sv
tb/tb_top.sv
